>>> rtl/core/sta_pkg.sv
// sta_pkg: constants and helpers shared by the slope-to-angle pipeline
// no dependencies
`default_nettype none
package sta_pkg;
    localparam int IN_W       = 16;
    localparam int OUT_W      = 16;
    localparam int WORK_FRAC  = 24;
    localparam int X_W        = 25;   // q.24 value up to 1.0
    localparam int MAG_W      = 17;
    localparam int IN_FRAC    = 8;
    localparam int OUT_FRAC   = 8;
    localparam int RQ_W       = 33;   // reciprocal quotient width
    localparam logic [X_W-1:0] ONE_WORK = X_W'(1) << WORK_FRAC;
    localparam logic [31:0] DEG_K = 32'd961263669;
    localparam logic [31:0] NINETY_Q24 = 32'd90 << WORK_FRAC;

    // truncating q.24 product of two values up to 1.0
    function automatic logic [X_W-1:0] mul_q24(input logic [X_W-1:0] a,
                                               input logic [X_W-1:0] b);
        logic [2*X_W-1:0] p;
        begin
            p = a * b;
            mul_q24 = p[WORK_FRAC +: X_W];
        end
    endfunction
endpackage
`default_nettype wire

>>> rtl/core/sta_recip.sv
// sta_recip: pipelined restoring divider, 2^32 / mag, one quotient bit a stage
// depends on sta_pkg
`default_nettype none
module sta_recip
    import sta_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             in_vld,
    input  wire logic [MAG_W-1:0] in_mag,
    input  wire logic             in_neg,
    output logic                  out_vld,
    output logic [X_W-1:0]        out_x,
    output logic                  out_neg,
    output logic                  out_rcp
);
    localparam int NS = RQ_W;
    localparam int R_W = MAG_W + 1;

    logic [NS:0]            vld_reg;
    logic [R_W-1:0]         rem_reg [NS+1];
    logic [RQ_W-1:0]        quo_reg [NS+1];
    logic [MAG_W-1:0]       div_reg [NS+1];
    logic [NS:0]            neg_reg;
    logic [NS:0]            rcp_reg;
    logic [X_W-1:0]         dir_reg [NS+1];

    // stage 0 captures the operand
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NS-1:0], in_vld};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= '0;
            quo_reg[0] <= '0;
            div_reg[0] <= in_mag;
            neg_reg[0] <= in_neg;
            rcp_reg[0] <= (in_mag >= MAG_W'(1 << IN_FRAC));
            dir_reg[0] <= X_W'(in_mag) << (WORK_FRAC - IN_FRAC);
        end
    end

    // one quotient bit per stage, dividend bit RQ_W-1-i of 2^32
    for (genvar i = 0; i < NS; i++)
    begin : g_div
        logic [R_W-1:0] r_sh;
        logic           dbit;
        always_comb
        begin
            dbit = (i == 0);
            r_sh = {rem_reg[i][R_W-2:0], dbit};
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (r_sh >= R_W'(div_reg[i]))
                begin
                    rem_reg[i+1] <= r_sh - R_W'(div_reg[i]);
                    quo_reg[i+1] <= {quo_reg[i][RQ_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[i+1] <= r_sh;
                    quo_reg[i+1] <= {quo_reg[i][RQ_W-2:0], 1'b0};
                end
                div_reg[i+1] <= div_reg[i];
                neg_reg[i+1] <= neg_reg[i];
                rcp_reg[i+1] <= rcp_reg[i];
                dir_reg[i+1] <= dir_reg[i];
            end
        end
    end

    // pick branch and clamp to 1.0
    always_comb
    begin
        out_vld = vld_reg[NS];
        out_neg = neg_reg[NS];
        out_rcp = rcp_reg[NS];
        if (!rcp_reg[NS])
            out_x = dir_reg[NS];
        else if (quo_reg[NS] > RQ_W'(ONE_WORK))
            out_x = ONE_WORK;
        else
            out_x = quo_reg[NS][X_W-1:0];
    end
endmodule
`default_nettype wire

>>> rtl/core/sta_series.sv
// sta_series: pipelined odd power series, degree scaling and output rounding
// depends on sta_pkg
`default_nettype none
module sta_series
    import sta_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire logic           in_vld,
    input  wire logic [X_W-1:0] in_x,
    input  wire logic           in_neg,
    input  wire logic           in_rcp,
    output logic                out_vld,
    output logic [OUT_W-1:0]    out_angle
);
    localparam int NS = 8;
    localparam int T_W = 28;
    localparam int M_DIV = 36;

    logic [NS:0]      vld_reg;
    logic [NS-1:0]    neg_reg;
    logic [NS-1:0]    rcp_reg;
    logic [X_W-1:0]   x_reg  [NS];
    logic [X_W-1:0]   x2_reg [NS];
    logic [X_W-1:0]   x3_reg, x5_reg, x7_reg, x9_reg;
    logic [X_W-1:0]   x3b_reg, x3c_reg, x3d_reg, x5b_reg, x5c_reg, x7b_reg;
    logic signed [T_W-1:0] t_reg;
    logic [31:0]      d_reg;
    logic [OUT_W-1:0] ang_reg;

    // reciprocal constants for exact floor division of 25-bit values
    function automatic logic [X_W-1:0] divc(input logic [X_W-1:0] v,
                                            input logic [M_DIV-1:0] m,
                                            input int unsigned c);
        logic [X_W+M_DIV-1:0] p;
        logic [X_W-1:0]       q;
        logic [X_W+3:0]       back;
        begin
            p = v * m;
            q = p[M_DIV +: X_W];
            back = (X_W+4)'(q) * (X_W+4)'(c);
            if ((X_W+4)'(v) >= back + (X_W+4)'(c))
                q = q + 1'b1;
            divc = q;
        end
    endfunction

    localparam logic [M_DIV-1:0] M3 = M_DIV'((64'd1 << M_DIV) / 3);
    localparam logic [M_DIV-1:0] M5 = M_DIV'((64'd1 << M_DIV) / 5);
    localparam logic [M_DIV-1:0] M7 = M_DIV'((64'd1 << M_DIV) / 7);
    localparam logic [M_DIV-1:0] M9 = M_DIV'((64'd1 << M_DIV) / 9);

    // valid shift line, one bit per register stage up to the angle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NS-1:0], in_vld};
    end

    // powers, one multiply per stage
    logic [X_W-1:0] t_sum_x;
    logic signed [T_W-1:0] t_next;
    logic [63:0] d_prod;
    logic [31:0] d_next;
    logic [31:0] r_full;
    logic [OUT_W-1:0] r_mag;

    always_comb
    begin
        t_sum_x = x_reg[5];
        t_next = T_W'($signed({3'b0, t_sum_x})) - T_W'($signed({3'b0, x3d_reg}))
               + T_W'($signed({3'b0, x5c_reg}))
               - T_W'($signed({3'b0, x7b_reg}))
               + T_W'($signed({3'b0, divc(x9_reg, M9, 9)}));
        if (t_next < 0)
            t_next = '0;
        d_prod = 64'(t_reg[X_W:0]) * 64'(DEG_K);
        d_next = d_prod[WORK_FRAC +: 32];
        if (rcp_reg[6])
            d_next = (d_next > NINETY_Q24) ? 32'd0 : NINETY_Q24 - d_next;
        r_full = (d_reg + (32'd1 << (WORK_FRAC - OUT_FRAC - 1))) >> (WORK_FRAC - OUT_FRAC);
        r_mag = (r_full > 32'd32767) ? 16'd32767 : r_full[OUT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]  <= in_x;
            neg_reg[0] <= in_neg;
            rcp_reg[0] <= in_rcp;
            x2_reg[1] <= mul_q24(x_reg[0], x_reg[0]);
            x3_reg    <= mul_q24(x2_reg[1], x_reg[1]);
            x2_reg[2] <= x2_reg[1];
            x5_reg    <= mul_q24(x3_reg, x2_reg[2]);
            x3b_reg   <= divc(x3_reg, M3, 3);
            x2_reg[3] <= x2_reg[2];
            x7_reg    <= mul_q24(x5_reg, x2_reg[3]);
            x5b_reg   <= divc(x5_reg, M5, 5);
            x3c_reg   <= x3b_reg;
            x9_reg    <= mul_q24(x7_reg, x2_reg[4]);
            x7b_reg   <= divc(x7_reg, M7, 7);
            x5c_reg   <= x5b_reg;
            x3d_reg   <= x3c_reg;
            t_reg     <= t_next;
            d_reg     <= d_next;
            ang_reg   <= neg_reg[7] ? OUT_W'(-r_mag) : r_mag;
            for (int i = 1; i < NS; i++)
            begin
                x_reg[i]   <= x_reg[i-1];
                neg_reg[i] <= neg_reg[i-1];
                rcp_reg[i] <= rcp_reg[i-1];
            end
            x2_reg[0] <= '0;
            for (int i = 4; i < NS; i++)
                x2_reg[i] <= x2_reg[i-1];
        end
    end

    assign out_vld   = vld_reg[NS];
    assign out_angle = ang_reg;
endmodule
`default_nettype wire

>>> rtl/core/slope_to_angle_arctan.sv
// slope_to_angle_arctan: arctangent of a q8.8 slope in q8.8 degrees
// depends on sta_pkg, sta_recip, sta_series
//
//  channel | signals                         | dir
//  in      | in_valid, in_stall, slope_q8    | sink
//  out     | out_valid, out_stall, angle_deg_q8 | source
//
// one beat per cycle unless stalled; 34 divider stages plus 9 series stages
// the reciprocal divider (one quotient bit a stage) sets the depth
// reset clears every valid bit; payload registers are not reset
// the whole pipeline holds while a valid result is stalled at the output
`default_nettype none
module slope_to_angle_arctan
    import sta_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [IN_W-1:0]   slope_q8,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [OUT_W-1:0]       angle_deg_q8
);
    logic             en;
    logic             neg;
    logic [MAG_W-1:0] mag;
    logic             r_vld, r_neg, r_rcp;
    logic [X_W-1:0]   r_x;

    // advance unless the output beat is held
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    // magnitude of the slope
    always_comb
    begin
        neg = slope_q8[IN_W-1];
        mag = neg ? MAG_W'(17'h10000 - {1'b0, slope_q8}) : MAG_W'(slope_q8);
    end

    sta_recip u_recip (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_vld(in_valid), .in_mag(mag), .in_neg(neg),
        .out_vld(r_vld), .out_x(r_x), .out_neg(r_neg), .out_rcp(r_rcp)
    );

    sta_series u_series (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_vld(r_vld), .in_x(r_x), .in_neg(r_neg), .in_rcp(r_rcp),
        .out_vld(out_valid), .out_angle(angle_deg_q8)
    );
endmodule
`default_nettype wire

>>> rtl/core/sta_checker.sv
// sta_checker: port-level checks on the slope-to-angle block
// depends on sta_pkg, binds to slope_to_angle_arctan
`default_nettype none
module sta_checker
    import sta_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             in_valid,
    input wire logic             in_stall,
    input wire logic             out_valid,
    input wire logic             out_stall,
    input wire logic [OUT_W-1:0] angle_deg_q8
);
    // stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(angle_deg_q8))
        else $error("result changed under stall");
    // input stalls only when output is held
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without cause");
    // angle within plus or minus 90 degrees
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($signed(angle_deg_q8) <= 16'sd23040)
                   && ($signed(angle_deg_q8) >= -16'sd23040))
        else $error("angle out of range");
    // in_valid, in_stall and out_valid always known out of reset
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({in_valid, in_stall, out_valid}))
        else $error("handshake line unknown");
endmodule

bind slope_to_angle_arctan sta_checker u_sta_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .angle_deg_q8(angle_deg_q8)
);
`default_nettype wire

>>> test/slope_to_angle_arctan_test.sv
// slope_to_angle_arctan_test: self-checking bench for the slope-to-angle arctangent pipeline
// depends on sta_pkg and slope_to_angle_arctan; predicts each angle and compares in order
`default_nettype none
module slope_to_angle_arctan_test;
    import sta_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AFTER   = 100;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 60;
    localparam int RAND_ITEMS   = 530;

    // outcome codes of a result comparison
    localparam int CMP_OK       = 0;
    localparam int CMP_MISMATCH = 1;
    localparam int CMP_ORPHAN   = 2;

    localparam longint unsigned ONE_Q24  = 64'd1 << 24;
    localparam longint unsigned K_Q24    =
        (((64'd180 << 24) * 64'd10000000) + 64'd15707963) / 64'd31415926;
    localparam longint unsigned N90_Q24  = 64'd90 << 24;

    // expected angles, oldest first
    class angle_book;
        logic [OUT_W-1:0] pending_angles[$];

        // odd arctangent series on a q.24 magnitude of at most one
        function longint unsigned series(input longint unsigned x);
            longint unsigned x2, x3, x5, x7, x9;
            longint sum;
            x2 = (x * x) >> 24;
            x3 = (x2 * x) >> 24;
            x5 = (x3 * x2) >> 24;
            x7 = (x5 * x2) >> 24;
            x9 = (x7 * x2) >> 24;
            sum = longint'(x) - longint'(x3 / 3) + longint'(x5 / 5)
                - longint'(x7 / 7) + longint'(x9 / 9);
            if (sum < 0)
                sum = 0;
            return longint'(sum);
        endfunction

        function logic [OUT_W-1:0] slope_angle(input logic [IN_W-1:0] slope);
            longint unsigned mag, x, deg, r;
            logic [OUT_W-1:0] ang;
            mag = slope[IN_W-1] ? (64'h10000 - 64'(slope)) : 64'(slope);
            if (mag < (64'd1 << IN_FRAC))
            begin
                x = mag << (24 - IN_FRAC);
                deg = (series(x) * K_Q24) >> 24;
            end
            else
            begin
                x = (64'd1 << (24 + IN_FRAC)) / mag;
                if (x > ONE_Q24)
                    x = ONE_Q24;
                deg = (series(x) * K_Q24) >> 24;
                deg = (deg > N90_Q24) ? 64'd0 : (N90_Q24 - deg);
            end
            r = (deg + (64'd1 << (23 - OUT_FRAC))) >> (24 - OUT_FRAC);
            if (r > 64'd32767)
                r = 64'd32767;
            ang = r[OUT_W-1:0];
            if (slope[IN_W-1])
                ang = -ang;
            return ang;
        endfunction

        function void note_slope(input logic [IN_W-1:0] slope);
            pending_angles.push_back(slope_angle(slope));
        endfunction

        function int check_angle(input logic [OUT_W-1:0] got, output logic [OUT_W-1:0] want);
            want = '0;
            if (pending_angles.size() == 0)
                return CMP_ORPHAN;
            want = pending_angles.pop_front();
            return (got === want) ? CMP_OK : CMP_MISMATCH;
        endfunction

        function int outstanding();
            return pending_angles.size();
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic [IN_W-1:0]  slope_q8;
    logic             out_valid;
    logic             out_stall;
    logic [OUT_W-1:0] angle_deg_q8;

    angle_book book;
    int  errors = 0;
    int  idle_cycles = 0;
    bit  no_gaps;

    slope_to_angle_arctan u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .slope_q8     (slope_q8),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .angle_deg_q8 (angle_deg_q8)
    );

    // clock
    always #5 clk = ~clk;

    task automatic report(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        errors++;
    endtask

    // offer one slope beat and wait until it is taken
    task automatic send_slope(input logic [IN_W-1:0] slope);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        slope_q8 <= slope;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        book.note_slope(slope);
    endtask

    task automatic wait_drained();
        while (book.outstanding() != 0)
            @(posedge clk);
    endtask

    // result sink with random stalls and one long hold after some beats
    initial
    begin
        int n;
        int taken;
        taken = 0;
        @(posedge rst_n);
        forever
        begin
            if (taken == HOLD_AFTER)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            n = no_gaps ? 0 : $urandom_range(0, 9);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            taken++;
        end
    end

    // compare every accepted result beat
    always @(posedge clk)
    begin
        logic [OUT_W-1:0] want;
        int outcome;
        if (rst_n && out_valid && !out_stall)
        begin
            outcome = book.check_angle(angle_deg_q8, want);
            if (outcome == CMP_ORPHAN)
                report($sformatf("unexpected angle %h", angle_deg_q8));
            else if (outcome == CMP_MISMATCH)
                report($sformatf("angle_deg_q8 got %h want %h", angle_deg_q8, want));
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        logic [IN_W-1:0] corner[$];
        logic [IN_W-1:0] s;
        rst_n = 1'b0;
        in_valid = 1'b0;
        slope_q8 = '0;
        out_stall = 1'b0;
        no_gaps = 1'b0;
        book = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero, unit magnitude either side, extremes and branch edges
        corner = '{16'h0000, 16'h0001, 16'hFFFF, 16'h00FF, 16'h0100, 16'h0101,
                   16'hFF00, 16'hFF01, 16'hFEFF, 16'h7FFF, 16'h8000, 16'h8001,
                   16'h0080, 16'hFF80, 16'h0200, 16'hFE00, 16'h03E8, 16'hFC18,
                   16'h7F00, 16'h0040, 16'h5555, 16'hAAAA};
        foreach (corner[i])
            send_slope(corner[i]);

        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            no_gaps = (i >= 200 && i < 260);
            if (i == 350)
            begin
                in_valid <= 1'b0;
                wait_drained();
            end
            s = IN_W'($urandom());
            // bias towards the direct branch and the area around one
            case ($urandom_range(0, 3))
                0: s = {{8{s[15]}}, s[7:0]};
                1: s = s[15] ? (16'hFF00 - 16'(s[8:0])) : (16'h0100 + 16'(s[8:0]));
                default: ;
            endcase
            send_slope(s);
        end
        in_valid <= 1'b0;
        no_gaps = 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (book.outstanding() != 0)
            report("angles still expected at end of run");
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire

>>> sim.f
rtl/core/sta_pkg.sv
rtl/core/sta_recip.sv
rtl/core/sta_series.sv
rtl/core/slope_to_angle_arctan.sv
rtl/core/sta_checker.sv
test/slope_to_angle_arctan_test.sv
